/* rtl/bq_pkg.sv */
// Shared constants, codes and types of the biquad filter core.
`timescale 1ns / 1ps
`default_nettype none

package bq_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 28;
    localparam int COEF_BITS          = 32;
    localparam int NUM_COEFS          = 5;
    localparam int COEF_IDX_BITS      = 3;
    localparam int APB_ADDR_BITS      = 5;
    localparam int APB_DATA_BITS      = 32;

    typedef logic [COEF_IDX_BITS-1:0] t_coef_idx;
    typedef logic [NUM_COEFS-1:0][COEF_BITS-1:0] t_coef_bank;

    // coefficient register indexes
    localparam t_coef_idx IDX_FEED0 = 3'd0;
    localparam t_coef_idx IDX_FEED1 = 3'd1;
    localparam t_coef_idx IDX_FEED2 = 3'd2;
    localparam t_coef_idx IDX_BACK1 = 3'd3;
    localparam t_coef_idx IDX_BACK2 = 3'd4;

    // multiplier sample operand select
    typedef logic [1:0] t_asel;
    localparam t_asel ASEL_IN = 2'd0;
    localparam t_asel ASEL_X  = 2'd1;
    localparam t_asel ASEL_Y  = 2'd2;

    // accumulate step codes
    typedef logic [2:0] t_op;
    localparam t_op OP_NONE  = 3'd0;
    localparam t_op OP_OUT   = 3'd1;
    localparam t_op OP_TADD  = 3'd2;
    localparam t_op OP_D1    = 3'd3;
    localparam t_op OP_TLOAD = 3'd4;
    localparam t_op OP_D2    = 3'd5;

    typedef struct packed {
        logic      load_x;
        t_asel     a_sel;
        t_coef_idx coef_idx;
        t_op       op;
        logic      load_out;
    } t_bq_cmd;

endpackage

`default_nettype wire

/* rtl/bq_in_if.sv */
// Input sample channel: valid, ready and one signed sample.
`timescale 1ns / 1ps
`default_nettype none

interface bq_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

/* rtl/bq_out_if.sv */
// Output sample channel: valid, ready, filtered sample and clip flag.
`timescale 1ns / 1ps
`default_nettype none

interface bq_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_out;
    logic                   clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

/* rtl/bq_regs.sv */
// APB coefficient register bank of the biquad filter.
`timescale 1ns / 1ps
`default_nettype none

module bq_regs #(
    parameter int COEF_FRAC_BITS = 28
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bq_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [bq_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [bq_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                   pready,
    output bq_pkg::t_coef_bank                     o_coefs
);
    import bq_pkg::*;

    localparam logic [COEF_BITS-1:0] FEED0_RST = COEF_BITS'(1) << COEF_FRAC_BITS;
    // feed0 sits in the lowest slot of the bank, all others reset to zero
    localparam t_coef_bank COEFS_RST = {{((NUM_COEFS-1)*COEF_BITS){1'b0}}, FEED0_RST};

    t_coef_bank r_coefs;
    t_coef_idx  w_idx;
    logic       w_wr;

    assign w_idx  = paddr[APB_ADDR_BITS-1:2];
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= COEFS_RST;
        end else if (w_wr) begin
            case (w_idx)
                IDX_FEED0: r_coefs[IDX_FEED0] <= pwdata;
                IDX_FEED1: r_coefs[IDX_FEED1] <= pwdata;
                IDX_FEED2: r_coefs[IDX_FEED2] <= pwdata;
                IDX_BACK1: r_coefs[IDX_BACK1] <= pwdata;
                IDX_BACK2: r_coefs[IDX_BACK2] <= pwdata;
                default: begin
                    // drop writes past the last register
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            IDX_FEED0: prdata = r_coefs[IDX_FEED0];
            IDX_FEED1: prdata = r_coefs[IDX_FEED1];
            IDX_FEED2: prdata = r_coefs[IDX_FEED2];
            IDX_BACK1: prdata = r_coefs[IDX_BACK1];
            IDX_BACK2: prdata = r_coefs[IDX_BACK2];
            default:   prdata = '0;
        endcase
    end

    assign o_coefs = r_coefs;

endmodule

`default_nettype wire

/* rtl/bq_ctrl.sv */
// Step sequencer of the biquad filter: handshakes and datapath commands.
`timescale 1ns / 1ps
`default_nettype none

module bq_ctrl (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output bq_pkg::t_bq_cmd o_cmd
);
    import bq_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_S1   = 3'd1;
    localparam logic [2:0] ST_S2   = 3'd2;
    localparam logic [2:0] ST_S3   = 3'd3;
    localparam logic [2:0] ST_S4   = 3'd4;
    localparam logic [2:0] ST_S5   = 3'd5;
    localparam logic [2:0] ST_HOLD = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;
    t_bq_cmd    w_cmd;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state        = r_state;
        w_cmd          = '0;
        w_cmd.a_sel    = ASEL_X;
        w_cmd.coef_idx = IDX_FEED0;
        w_cmd.op       = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                w_cmd.load_x = i_in_valid;
                w_cmd.a_sel  = ASEL_IN;
                if (i_in_valid) begin
                    n_state = ST_S1;
                end
            end
            ST_S1: begin
                w_cmd.op       = OP_OUT;
                w_cmd.coef_idx = IDX_FEED1;
                n_state        = ST_S2;
            end
            ST_S2: begin
                w_cmd.op       = OP_TADD;
                w_cmd.a_sel    = ASEL_Y;
                w_cmd.coef_idx = IDX_BACK1;
                n_state        = ST_S3;
            end
            ST_S3: begin
                w_cmd.op       = OP_D1;
                w_cmd.coef_idx = IDX_FEED2;
                n_state        = ST_S4;
            end
            ST_S4: begin
                w_cmd.op       = OP_TLOAD;
                w_cmd.a_sel    = ASEL_Y;
                w_cmd.coef_idx = IDX_BACK2;
                n_state        = ST_S5;
            end
            ST_S5: begin
                w_cmd.op       = OP_D2;
                w_cmd.load_out = w_out_free;
                n_state        = w_out_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD: begin
                w_cmd.load_out = w_out_free;
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

`default_nettype wire

/* rtl/bq_dpath.sv */
// Biquad datapath: shared multiplier, accumulators, state and output word.
`timescale 1ns / 1ps
`default_nettype none

module bq_dpath #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire bq_pkg::t_bq_cmd        i_cmd,
    input  wire bq_pkg::t_coef_bank     i_coefs,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic      [SAMPLE_BITS-1:0] o_sample,
    output logic                        o_clipped
);
    import bq_pkg::*;

    localparam int DB = SAMPLE_BITS + COEF_BITS;  // state and product width
    localparam int AW = DB + 1;                   // output accumulator
    localparam int TW = DB + 2;                   // state update sum

    localparam logic signed [AW-1:0] ROUND_BIAS = AW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] Y_MAX = {{(AW-SAMPLE_BITS+1){1'b0}},
                                              {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [AW-1:0] Y_MIN = ~Y_MAX;
    localparam logic signed [TW-1:0] D_MAX = {{(TW-DB+1){1'b0}}, {(DB-1){1'b1}}};
    localparam logic signed [TW-1:0] D_MIN = ~D_MAX;

    logic signed [SAMPLE_BITS-1:0] r_x, r_y, w_mul_a;
    logic signed [COEF_BITS-1:0]   w_mul_b;
    logic signed [DB-1:0]          r_prod, w_prod;
    logic signed [DB-1:0]          r_d1, r_d2, w_dsat;
    logic signed [AW-1:0]          w_acc, w_shift;
    logic signed [TW-1:0]          r_t, w_diff;
    logic signed [SAMPLE_BITS-1:0] w_ysat;
    logic                          r_clip, w_clip;
    logic [SAMPLE_BITS-1:0]        r_out_sample;
    logic                          r_out_clip;

    always_comb begin
        case (i_cmd.a_sel)
            ASEL_IN: w_mul_a = i_sample;
            ASEL_X:  w_mul_a = r_x;
            ASEL_Y:  w_mul_a = r_y;
            default: w_mul_a = r_x;
        endcase
        case (i_cmd.coef_idx)
            IDX_FEED0: w_mul_b = i_coefs[IDX_FEED0];
            IDX_FEED1: w_mul_b = i_coefs[IDX_FEED1];
            IDX_FEED2: w_mul_b = i_coefs[IDX_FEED2];
            IDX_BACK1: w_mul_b = i_coefs[IDX_BACK1];
            IDX_BACK2: w_mul_b = i_coefs[IDX_BACK2];
            default:   w_mul_b = '0;
        endcase
    end

    assign w_prod = DB'(w_mul_a) * DB'(w_mul_b);

    // round half up, shift down to sample scale, clamp
    assign w_acc   = AW'(r_prod) + AW'(r_d1) + ROUND_BIAS;
    assign w_shift = w_acc >>> COEF_FRAC_BITS;

    always_comb begin
        w_clip = 1'b1;
        if (w_shift > Y_MAX) begin
            w_ysat = Y_MAX[SAMPLE_BITS-1:0];
        end else if (w_shift < Y_MIN) begin
            w_ysat = Y_MIN[SAMPLE_BITS-1:0];
        end else begin
            w_ysat = w_shift[SAMPLE_BITS-1:0];
            w_clip = 1'b0;
        end
    end

    // subtract the feedback product and clamp to the state width
    assign w_diff = r_t - TW'(r_prod);

    always_comb begin
        if (w_diff > D_MAX) begin
            w_dsat = D_MAX[DB-1:0];
        end else if (w_diff < D_MIN) begin
            w_dsat = D_MIN[DB-1:0];
        end else begin
            w_dsat = w_diff[DB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_cmd.load_x) begin
            r_x <= i_sample;
        end
        case (i_cmd.op)
            OP_OUT: begin
                r_y    <= w_ysat;
                r_clip <= w_clip;
            end
            OP_TADD:  r_t <= TW'(r_prod) + TW'(r_d2);
            OP_TLOAD: r_t <= TW'(r_prod);
            default: begin
            end
        endcase
        if (i_cmd.load_out) begin
            r_out_sample <= r_y;
            r_out_clip   <= r_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else begin
            if (i_cmd.op == OP_D1) begin
                r_d1 <= w_dsat;
            end
            if (i_cmd.op == OP_D2) begin
                r_d2 <= w_dsat;
            end
        end
    end

    assign o_sample  = r_out_sample;
    assign o_clipped = r_out_clip;

endmodule

`default_nettype wire

/* rtl/biquad_iir_filter_core.sv */
// Top level of the biquad IIR filter core: register bank, sequencer, datapath.
`timescale 1ns / 1ps
`default_nettype none

// Second-order IIR section in transposed direct form II. Each word taken on
// i_in (a signed sample) gives one word on o_out: the filtered sample, rounded
// half up and saturated to the sample width, with a flag set when it clipped.
// The five coefficients are signed Q3.28 registers on the APB port at byte
// addresses 0x00 (feed0), 0x04 (feed1), 0x08 (feed2), 0x0C (back1) and 0x10
// (back2); feed0 resets to 1.0 and the rest to zero, so the core passes the
// input through after reset. Write coefficients only while no sample is in
// flight. The two state accumulators are sample width plus 32 bits, clear at
// reset, and clamp on overflow.
// Only one sample is in the steps at a time. A single shared multiplier
// carries all five products, one per cycle, and the output must be formed
// before the feedback products can start, so the sequencer walks the
// acceptance cycle plus five steps. The result enters the output register at
// the last step, or from the hold state. The next sample is taken while the
// previous result still waits in the output register; the sequencer only holds
// when a second result is ready and the first has not been taken yet.
module biquad_iir_filter_core #(
    parameter int SAMPLE_BITS    = bq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = bq_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    bq_in_if.sink                                  i_in,
    bq_out_if.source                               o_out,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bq_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [bq_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [bq_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                   pready
);
    import bq_pkg::*;

    t_coef_bank             w_coefs;
    t_bq_cmd                w_cmd;
    logic [SAMPLE_BITS-1:0] w_sample_out;
    logic                   w_clipped;

    // coefficient registers
    bq_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (w_coefs)
    );

    // sequence the multiply and accumulate steps of one sample
    bq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    // shared multiplier, output rounding and state update
    bq_dpath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_coefs   (w_coefs),
        .i_sample  (i_in.sample_in),
        .o_sample  (w_sample_out),
        .o_clipped (w_clipped)
    );

    assign o_out.sample_out = w_sample_out;
    assign o_out.clipped    = w_clipped;

endmodule

`default_nettype wire
